FILE: sv/tbdp_pkg.sv
// ----------------------------------------------------------------------------
// tbdp_pkg: shared types and constants of the two-button debounce panel
// Payload structs of both channels, the button A debouncer states and the
// mode range.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package tbdp_pkg;

  // Number of selectable modes; the mode steps 1..MODE_COUNT and wraps to 1
  localparam int MODE_COUNT = 7;
  localparam int MODE_BITS  = $clog2(MODE_COUNT + 1);
  // Internal mode register is never narrower than the 3-bit mode field
  localparam int MODE_W     = (MODE_BITS > 3) ? MODE_BITS : 3;

  // Reset value of the debounce length register
  localparam logic [7:0] DEBOUNCE_RESET = 8'd3;

  // Button A debouncer states
  typedef enum logic [1:0] {
    A_IDLE        = 2'd0,
    A_DEB_PRESS   = 2'd1,
    A_PRESSED     = 2'd2,
    A_DEB_RELEASE = 2'd3
  } a_state_t;

  // One scan tick
  typedef struct packed {
    logic pin_a_level;
    logic pin_b_level;
  } tick_t;

  // Panel status after one tick
  typedef struct packed {
    logic [2:0] mode;
    logic       running;
    logic       key_a_event;
    logic       key_b_event;
    logic       motor_stop;
  } status_t;

endpackage

FILE: sv/tbdp_if.sv
// ----------------------------------------------------------------------------
// tbdp_if: valid/ready channels of the two-button debounce panel
// tbdp_tick_if carries scan ticks, tbdp_status_if carries panel status.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

interface tbdp_tick_if;
  logic           valid;
  logic           ready;
  tbdp_pkg::tick_t payload;

  modport source (output valid, output payload, input ready);
  modport sink   (input valid, input payload, output ready);
endinterface

interface tbdp_status_if;
  logic             valid;
  logic             ready;
  tbdp_pkg::status_t payload;

  modport source (output valid, output payload, input ready);
  modport sink   (input valid, input payload, output ready);
endinterface

FILE: sv/two_button_debounce_panel_top.sv
// ----------------------------------------------------------------------------
// two_button_debounce_panel_top: two-button control panel with debounce
// Takes one scan tick per cycle (pin levels of buttons A and B) and returns
// one status transaction per tick: mode, running, the two key events and the
// motor stop pulse. A tick passes an input register and a result register,
// so its status is offered on the result channel once it reaches the result register;
// a new tick is taken in every cycle while the status side keeps up, and one
// more tick is taken while a finished status waits. Button A (active low) is
// confirmed after debounce_ticks stable ticks that follow its first pressed
// tick. The user writes debounce_ticks through cfg_we/cfg_wdata only while
// the panel is idle (reset value 3); the block itself does not enforce this.
// A confirmed press steps the mode only while the car is stopped. Button B
// learns its idle level on the first tick and toggles running once per
// departure from idle; stopping a running car raises motor_stop.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module two_button_debounce_panel_top (
  input  logic                 clk,
  input  logic                 rst_n,
  tbdp_tick_if.sink            in_ch,
  tbdp_status_if.source        out_ch,
  input  logic                 cfg_we,
  input  logic [7:0]           cfg_wdata
);
  import tbdp_pkg::*;

  // Configuration
  logic [7:0]        debounce_ticks_r;

  // Input register
  logic              in_valid_r;
  tick_t             in_r;

  // Result register
  logic              out_valid_r;
  status_t           out_r;

  // Panel state
  a_state_t          a_state_r, a_state_nxt;
  logic [7:0]        a_count_r, a_count_nxt;
  logic              first_done_r;
  logic              b_idle_r, b_idle_nxt;
  logic              b_latched_r, b_latched_nxt;
  logic [MODE_W-1:0] mode_r, mode_nxt;
  logic              started_r, started_nxt;

  // Handshake
  logic              out_free;
  logic              advance;

  // Tick evaluation
  logic              a_pressed;
  a_state_t          a_state_eff;
  logic [7:0]        a_count_eff;
  logic [7:0]        a_count_inc;
  logic              a_confirm;
  logic              ev_a;
  logic              ev_b;
  logic              stop;
  logic              b_idle_eff;
  logic              b_latched_eff;

  assign out_free     = !out_valid_r || out_ch.ready;
  assign advance      = in_valid_r && out_free;
  assign in_ch.ready  = !in_valid_r || out_free;
  assign out_ch.valid = out_valid_r;
  assign out_ch.payload = out_r;

  // Hold the debounce length
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      debounce_ticks_r <= DEBOUNCE_RESET;
    end else if (cfg_we) begin
      debounce_ticks_r <= cfg_wdata;
    end
  end

  // Capture an accepted tick
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_valid_r <= 1'b0;
    end else if (in_ch.ready) begin
      in_valid_r <= in_ch.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ch.valid && in_ch.ready) begin
      in_r <= in_ch.payload;
    end
  end

  // On the first tick a held A starts in pressed and B learns its idle level
  assign a_pressed     = !in_r.pin_a_level;
  assign a_state_eff   = (!first_done_r && a_pressed) ? A_PRESSED : a_state_r;
  assign a_count_eff   = (!first_done_r && a_pressed) ? 8'd0 : a_count_r;
  assign b_idle_eff    = first_done_r ? b_idle_r : in_r.pin_b_level;
  assign b_latched_eff = first_done_r && b_latched_r;

  assign a_count_inc = a_count_eff + 8'd1;
  assign a_confirm   = (a_count_inc >= debounce_ticks_r);

  // Button A debouncer: next state and press event
  always_comb begin
    a_state_nxt = a_state_eff;
    a_count_nxt = a_count_eff;
    ev_a        = 1'b0;
    case (a_state_eff)
      A_IDLE: begin
        if (a_pressed) begin
          a_state_nxt = A_DEB_PRESS;
          a_count_nxt = 8'd0;
        end
      end
      A_DEB_PRESS: begin
        if (a_pressed) begin
          a_count_nxt = a_count_inc;
          if (a_confirm) begin
            a_state_nxt = A_PRESSED;
            ev_a        = 1'b1;
          end
        end else begin
          a_state_nxt = A_IDLE;
        end
      end
      A_PRESSED: begin
        if (!a_pressed) begin
          a_state_nxt = A_DEB_RELEASE;
          a_count_nxt = 8'd0;
        end
      end
      A_DEB_RELEASE: begin
        if (!a_pressed) begin
          a_count_nxt = a_count_inc;
          if (a_confirm) begin
            a_state_nxt = A_IDLE;
          end
        end else begin
          a_state_nxt = A_PRESSED;
        end
      end
      default: begin
        a_state_nxt = A_IDLE;
      end
    endcase
  end

  // Step the mode on a confirmed press while stopped, before B toggles running
  always_comb begin
    mode_nxt = mode_r;
    if (ev_a && !started_r) begin
      if (mode_r >= MODE_W'(MODE_COUNT)) begin
        mode_nxt = MODE_W'(1);
      end else begin
        mode_nxt = mode_r + MODE_W'(1);
      end
    end
  end

  // Button B: fire once per departure from idle and toggle running
  always_comb begin
    b_idle_nxt    = b_idle_eff;
    b_latched_nxt = b_latched_eff;
    started_nxt   = started_r;
    ev_b          = 1'b0;
    stop          = 1'b0;
    if (in_r.pin_b_level != b_idle_eff) begin
      if (!b_latched_eff) begin
        b_latched_nxt = 1'b1;
        ev_b          = 1'b1;
        started_nxt   = !started_r;
        stop          = started_r;
      end
    end else begin
      b_latched_nxt = 1'b0;
    end
  end

  // Advance panel state with each tick that moves to the result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      a_state_r    <= A_IDLE;
      a_count_r    <= 8'd0;
      first_done_r <= 1'b0;
      b_idle_r     <= 1'b0;
      b_latched_r  <= 1'b0;
      mode_r       <= MODE_W'(1);
      started_r    <= 1'b0;
    end else if (advance) begin
      a_state_r    <= a_state_nxt;
      a_count_r    <= a_count_nxt;
      first_done_r <= 1'b1;
      b_idle_r     <= b_idle_nxt;
      b_latched_r  <= b_latched_nxt;
      mode_r       <= mode_nxt;
      started_r    <= started_nxt;
    end
  end

  // Hold the status until the sink takes it
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (out_free) begin
      out_valid_r <= in_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      out_r.mode        <= mode_nxt[2:0];
      out_r.running     <= started_nxt;
      out_r.key_a_event <= ev_a;
      out_r.key_b_event <= ev_b;
      out_r.motor_stop  <= stop;
    end
  end

  // A stop pulse only comes from a B event that leaves the car stopped
  assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && out_r.motor_stop |-> out_r.key_b_event && !out_r.running)
    else $error("motor_stop without a B event that stops the car");

  // Mode stays within 1..MODE_COUNT
  assert property (@(posedge clk) disable iff (!rst_n)
    (mode_r != '0) && (mode_r <= MODE_W'(MODE_COUNT)))
    else $error("mode register out of range");

  // Running changes only through a B event
  assert property (@(posedge clk) disable iff (!rst_n)
    advance && (started_nxt != started_r) |-> ev_b)
    else $error("running changed without a B event");

  // A stalled status is not overwritten
  assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && !out_ch.ready |=> out_valid_r && $stable(out_r))
    else $error("stalled status changed");

endmodule
